// ===== src/rzs_pkg.sv =====
// Shared types and constants of the rolling z-score block.
`default_nettype none

package rzs_pkg;

   localparam int SAMPLE_W      = 24;
   localparam int ZSCORE_W      = 24;
   localparam int WLEN_W        = 9;
   localparam int WLEN_RESET    = 20;
   localparam int FRAC_SHIFT    = 16;
   localparam int QUO_BITS      = 24;
   localparam int DIV_PRESHIFT  = QUO_BITS - FRAC_SHIFT;

   localparam logic [ZSCORE_W-1:0] Z_POS_LIMIT = 24'h7F_FFFF;
   localparam logic [ZSCORE_W-1:0] Z_NEG_LIMIT = 24'h80_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_EVICT,
      ST_UPDATE,
      ST_MUL,
      ST_SQUARE,
      ST_DIFF,
      ST_SQRT,
      ST_DIV_CHECK,
      ST_DIV,
      ST_DONE
   } rzs_state_type;

   typedef struct packed {
      logic accept;
      logic cfg_write;
      logic load;
      logic evict;
      logic update;
      logic mul;
      logic square;
      logic diff;
      logic sqrt_step;
      logic div_init;
      logic div_step;
      logic out_load;
   } rzs_cmd_type;

   typedef struct packed {
      logic valid;
      logic flat;
   } rzs_status_type;

endpackage

`default_nettype wire

// ===== src/rzs_if.sv =====
// Channel interfaces of the rolling z-score block: sample, result and window length.
`default_nettype none

interface rzs_req_if import rzs_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] spread_sample;
   logic                       series_start;

   modport source (output valid, spread_sample, series_start, input ready);
   modport sink (input valid, spread_sample, series_start, output ready);
endinterface

interface rzs_rsp_if import rzs_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [ZSCORE_W-1:0] zscore;
   logic                       zscore_valid;
   logic                       flat_window;

   modport source (output valid, zscore, zscore_valid, flat_window, input ready);
   modport sink (input valid, zscore, zscore_valid, flat_window, output ready);
endinterface

interface rzs_csr_if import rzs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WLEN_W-1:0] write_data;

   modport source (output valid, write_data, input ready);
   modport sink (input valid, write_data, output ready);
endinterface

`default_nettype wire

// ===== src/rzs_datapath.sv =====
// Datapath of the rolling z-score block: sample ring, running sums, square root and divider.
`default_nettype none

module rzs_datapath import rzs_pkg::*; #(
   parameter int MAX_WINDOW = 256
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire rzs_cmd_type                cmd,
   output      rzs_status_type             status,
   input  wire logic signed [SAMPLE_W-1:0] req_sample,
   input  wire logic                       req_start,
   input  wire logic [WLEN_W-1:0]          csr_data,
   output      logic signed [ZSCORE_W-1:0] rsp_zscore,
   output      logic                       rsp_zscore_valid,
   output      logic                       rsp_flat_window
);

   localparam int AB   = $clog2(MAX_WINDOW);
   localparam int WB   = $clog2(MAX_WINDOW + 1);
   localparam int SW   = SAMPLE_W + AB;
   localparam int SQW  = 2 * SAMPLE_W;
   localparam int QW   = 2 * SAMPLE_W - 1 + AB;
   localparam int DW   = 2 * SAMPLE_W - 1 + 2 * AB;
   localparam int RB   = SAMPLE_W + AB;
   localparam int NW   = SAMPLE_W + AB + 2;
   localparam int NM   = NW - 1;
   localparam int CW   = (NM > RB + DIV_PRESHIFT) ? NM : RB + DIV_PRESHIFT;
   localparam int W_RESET = (WLEN_RESET > MAX_WINDOW) ? MAX_WINDOW : WLEN_RESET;

   logic [WB-1:0]              w_ff, w_in;
   logic signed [SW-1:0]       sum_ff, sum_in;
   logic [QW-1:0]              sqs_ff, sqs_in;
   logic [WB-1:0]              fill_ff, fill_in;
   logic [AB-1:0]              pos_ff, pos_in;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic                       start_ff;
   logic signed [SAMPLE_W-1:0] ring_ff [MAX_WINDOW];
   logic signed [SAMPLE_W-1:0] old_ff;
   logic                       evict_ff, evict_in;
   logic                       valid_ff, valid_in;
   logic [SQW-1:0]             xsq_ff, xsq_in;
   logic [SQW-1:0]             osq_ff, osq_in;
   logic [DW-1:0]              wq_ff, wq_in;
   logic [SW-1:0]              smag_ff, smag_in;
   logic signed [NW-1:0]       num_ff, num_in;
   logic [DW-1:0]              ss_ff, ss_in;
   logic                       flat_ff;
   logic                       neg_ff;
   logic [NM-1:0]              nm_ff, nm_in;
   logic [2*RB-1:0]            rad_ff, rad_in;
   logic [RB:0]                rem_ff, rem_in;
   logic [RB-1:0]              root_ff, root_in;
   logic [RB-1:0]              drem_ff, drem_in;
   logic [QUO_BITS-1:0]        dlo_ff, dlo_in;
   logic [QUO_BITS-1:0]        quo_ff, quo_in;
   logic                       ovf_ff, ovf_in;
   logic signed [ZSCORE_W-1:0] z_ff, z_in;
   logic                       zvalid_ff, flat_out_ff;

   logic [AB-1:0]              pos_cur;
   logic [WB-1:0]              fill_cur;
   logic [AB:0]                leave_sum;
   logic [AB-1:0]              leave_addr;
   logic [WB-1:0]              w_sat;
   logic [SAMPLE_W-1:0]        xm, om;
   logic [DW:0]                diff;
   logic                       flat_now;
   logic [RB+2:0]              sq_shift, sq_trial;
   logic                       sq_ge;
   logic [RB:0]                dv_trial;
   logic                       dv_ge;

   // Window length as used: zero acts as one, values above the ring depth saturate.
   always_comb begin
      priority if (csr_data == '0) begin
         w_sat = WB'(1);
      end else if (32'(csr_data) > 32'(MAX_WINDOW)) begin
         w_sat = WB'(MAX_WINDOW);
      end else begin
         w_sat = WB'(csr_data);
      end
   end

   assign pos_cur    = start_ff ? '0 : pos_ff;
   assign fill_cur   = start_ff ? '0 : fill_ff;
   assign leave_sum  = (AB+1)'(pos_cur) + (AB+1)'(MAX_WINDOW) - (AB+1)'(w_ff);
   assign leave_addr = (leave_sum >= (AB+1)'(MAX_WINDOW)) ?
                       AB'(leave_sum - (AB+1)'(MAX_WINDOW)) : AB'(leave_sum);
   assign evict_in   = fill_cur >= w_ff;
   assign xm         = SAMPLE_W'(x_ff[SAMPLE_W-1] ? -x_ff : x_ff);
   assign om         = SAMPLE_W'(old_ff[SAMPLE_W-1] ? -old_ff : old_ff);
   assign diff       = {1'b0, wq_ff} - {1'b0, ss_ff};
   assign flat_now   = diff[DW] || (diff == '0);

   always_comb begin
      w_in    = w_ff;
      sum_in  = sum_ff;
      sqs_in  = sqs_ff;
      fill_in = fill_ff;
      pos_in  = pos_ff;
      if (cmd.cfg_write) begin
         w_in    = w_sat;
         sum_in  = '0;
         sqs_in  = '0;
         fill_in = '0;
         pos_in  = '0;
      end else if (cmd.load) begin
         fill_in = evict_in ? fill_cur : fill_cur + WB'(1);
         pos_in  = (pos_cur == AB'(MAX_WINDOW - 1)) ? '0 : pos_cur + AB'(1);
         if (start_ff) begin
            sum_in = '0;
            sqs_in = '0;
         end
      end else if (cmd.update) begin
         sum_in = sum_ff + SW'(x_ff) - (evict_ff ? SW'(old_ff) : {SW{1'b0}});
         sqs_in = sqs_ff + QW'(xsq_ff) - (evict_ff ? QW'(osq_ff) : {QW{1'b0}});
      end
   end

   assign valid_in = evict_in || ((fill_cur + WB'(1)) >= w_ff);
   assign xsq_in   = SQW'(xm) * SQW'(xm);
   assign osq_in   = SQW'(om) * SQW'(om);
   assign wq_in    = DW'(w_ff) * DW'(sqs_ff);
   assign num_in   = NW'($signed({1'b0, w_ff})) * NW'(x_ff) - NW'(sum_ff);
   assign smag_in  = SW'(sum_ff[SW-1] ? -sum_ff : sum_ff);
   assign ss_in    = DW'(smag_ff) * DW'(smag_ff);
   assign nm_in    = NM'(num_ff[NW-1] ? -num_ff : num_ff);

   // Floor square root, one root bit per step.
   assign sq_shift = {rem_ff, rad_ff[2*RB-1 -: 2]};
   assign sq_trial = (RB+3)'({root_ff, 2'b01});
   assign sq_ge    = sq_shift >= sq_trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (cmd.diff) begin
         rad_in  = (2*RB)'(diff[DW-1:0]);
         rem_in  = '0;
         root_in = '0;
      end else if (cmd.sqrt_step) begin
         rad_in  = rad_ff << 2;
         rem_in  = sq_ge ? (RB+1)'(sq_shift - sq_trial) : (RB+1)'(sq_shift);
         root_in = {root_ff[RB-2:0], sq_ge};
      end
   end

   // Restoring divide of the magnitude scaled by 2^16, one quotient bit per step.
   assign dv_trial = {drem_ff, dlo_ff[QUO_BITS-1]};
   assign dv_ge    = dv_trial >= {1'b0, root_ff};

   always_comb begin
      drem_in = drem_ff;
      dlo_in  = dlo_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      if (cmd.div_init) begin
         ovf_in  = CW'(nm_ff) >= (CW'(root_ff) << DIV_PRESHIFT);
         drem_in = RB'(nm_ff >> DIV_PRESHIFT);
         dlo_in  = QUO_BITS'({nm_ff[DIV_PRESHIFT-1:0], {FRAC_SHIFT{1'b0}}});
         quo_in  = '0;
      end else if (cmd.div_step) begin
         drem_in = dv_ge ? RB'(dv_trial - {1'b0, root_ff}) : RB'(dv_trial);
         dlo_in  = dlo_ff << 1;
         quo_in  = {quo_ff[QUO_BITS-2:0], dv_ge};
      end
   end

   always_comb begin
      priority if (!valid_ff || flat_ff) begin
         z_in = '0;
      end else if (neg_ff) begin
         z_in = (ovf_ff || quo_ff > Z_NEG_LIMIT) ? Z_NEG_LIMIT : -quo_ff;
      end else begin
         z_in = (ovf_ff || quo_ff > Z_POS_LIMIT) ? Z_POS_LIMIT : quo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff    <= WB'(W_RESET);
         sum_ff  <= '0;
         sqs_ff  <= '0;
         fill_ff <= '0;
         pos_ff  <= '0;
      end else begin
         w_ff    <= w_in;
         sum_ff  <= sum_in;
         sqs_ff  <= sqs_in;
         fill_ff <= fill_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ring_ff[pos_cur] <= x_ff;
         old_ff           <= ring_ff[leave_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         x_ff     <= req_sample;
         start_ff <= req_start;
      end
      if (cmd.load) begin
         evict_ff <= evict_in;
         valid_ff <= valid_in;
         xsq_ff   <= xsq_in;
      end
      if (cmd.evict) begin
         osq_ff <= osq_in;
      end
      if (cmd.mul) begin
         wq_ff   <= wq_in;
         num_ff  <= num_in;
         smag_ff <= smag_in;
      end
      if (cmd.square) begin
         ss_ff <= ss_in;
      end
      if (cmd.diff) begin
         flat_ff <= flat_now;
         neg_ff  <= num_ff[NW-1];
         nm_ff   <= nm_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      drem_ff <= drem_in;
      dlo_ff  <= dlo_in;
      quo_ff  <= quo_in;
      ovf_ff  <= ovf_in;
      if (cmd.out_load) begin
         z_ff        <= z_in;
         zvalid_ff   <= valid_ff;
         flat_out_ff <= valid_ff && flat_ff;
      end
   end

   assign status.valid     = valid_ff;
   assign status.flat      = flat_now;
   assign rsp_zscore       = z_ff;
   assign rsp_zscore_valid = zvalid_ff;
   assign rsp_flat_window  = flat_out_ff;

endmodule

`default_nettype wire

// ===== src/rzs_controller.sv =====
// Sequencer of the rolling z-score block: handshakes, step order and iteration counts.
`default_nettype none

module rzs_controller import rzs_pkg::*; #(
   parameter int ROOT_BITS = 32
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output      logic           req_ready,
   input  wire logic           csr_valid,
   output      logic           csr_ready,
   output      logic           rsp_valid,
   input  wire logic           rsp_ready,
   input  wire rzs_status_type status,
   output      rzs_cmd_type    cmd
);

   localparam int CNT_W = $clog2((ROOT_BITS > QUO_BITS) ? ROOT_BITS : QUO_BITS);

   rzs_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      csr_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            csr_ready = 1'b1;
            req_ready = !csr_valid;
            if (csr_valid) begin
               cmd.cfg_write = 1'b1;
            end else if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_EVICT;
         end
         ST_EVICT: begin
            cmd.evict = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.valid ? ST_MUL : ST_DONE;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            cnt_in   = CNT_W'(ROOT_BITS - 1);
            state_in = status.flat ? ST_DONE : ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_DIV_CHECK;
            end
         end
         ST_DIV_CHECK: begin
            cmd.div_init = 1'b1;
            cnt_in       = CNT_W'(QUO_BITS - 1);
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== src/rolling_zscore_core.sv =====
// Top level of the rolling z-score block.
// Each sample beat is loaded, evicts the old sample and updates the sums; if the
// window is not yet full the result follows. Else multiply, square and difference run,
// and a flat window ends there; else the bit-serial square root of ROOT_BITS =
// 24 + clog2(MAX_WINDOW) bits (32 at MAX_WINDOW 256) and the divider run. One sample
// is in work at a time. Synchronous reset sets the window length to 20 and empties it.
`default_nettype none

module rolling_zscore_core import rzs_pkg::*; #(
   parameter int MAX_WINDOW = 256
) (
   input wire logic clock,
   input wire logic reset,
   rzs_req_if.sink   req_bus,
   rzs_rsp_if.source rsp_bus,
   rzs_csr_if.sink   csr_bus
);

   localparam int ROOT_BITS = SAMPLE_W + $clog2(MAX_WINDOW);

   rzs_cmd_type    cmd;
   rzs_status_type status;

   rzs_controller #(
      .ROOT_BITS (ROOT_BITS)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .csr_valid (csr_bus.valid),
      .csr_ready (csr_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rzs_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_sample       (req_bus.spread_sample),
      .req_start        (req_bus.series_start),
      .csr_data         (csr_bus.write_data),
      .rsp_zscore       (rsp_bus.zscore),
      .rsp_zscore_valid (rsp_bus.zscore_valid),
      .rsp_flat_window  (rsp_bus.flat_window)
   );

   a_one_sample_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("sample beat taken while another sample is in work");

   a_cfg_excludes_sample: assert property (@(posedge clock) disable iff (reset)
      (csr_bus.valid && csr_bus.ready) |-> !(req_bus.valid && req_bus.ready))
      else $error("window length write and sample beat in the same cycle");

   a_not_full_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.zscore_valid) |->
         (rsp_bus.zscore == '0 && !rsp_bus.flat_window))
      else $error("result before a full window is not cleared");

   a_flat_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.flat_window) |->
         (rsp_bus.zscore == '0 && rsp_bus.zscore_valid))
      else $error("flat window result is not a valid zero");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the rolling z-score core with random beat pacing.
`timescale 1ns / 1ps

module tb import rzs_pkg::*; ();

   localparam int unsigned MAX_WINDOW    = 256;
   localparam int unsigned RANDOM_ITEMS  = 750;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned TAIL_CYCLES   = 200;
   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam longint      SAMPLE_MAX    = 2**(SAMPLE_W-1) - 1;
   localparam longint      SAMPLE_MIN    = -(2**(SAMPLE_W-1));
   localparam int unsigned WLEN_MAX      = 2**WLEN_W - 1;
   localparam int unsigned PHASE_WINDOWS [7] = '{256, 511, 1, 0, 2, 3, 20};

   typedef enum logic [1:0] {BEAT_SAMPLE, BEAT_WLEN, BEAT_DRAIN} beat_kind_type;
   typedef enum logic [1:0] {SHAPE_WIDE, SHAPE_NEAR, SHAPE_FLAT, SHAPE_EXTREME} shape_type;

   typedef struct {
      beat_kind_type              kind;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       series_start;
      logic [WLEN_W-1:0]          wlen;
   } stim_beat_type;

   typedef struct {
      logic signed [ZSCORE_W-1:0] zscore;
      logic                       zscore_valid;
      logic                       flat_window;
   } zscore_beat_type;

   logic clock;
   logic reset;

   rzs_req_if req_bus ();
   rzs_rsp_if rsp_bus ();
   rzs_csr_if csr_bus ();

   rolling_zscore_core #(.MAX_WINDOW(MAX_WINDOW)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   stim_beat_type   pending_beats [$];
   zscore_beat_type zscores_due [$];
   int unsigned     failures;
   int unsigned     cycle_count;

   logic signed [SAMPLE_W-1:0] spread_ring [MAX_WINDOW];
   longint                     run_sum;
   longint                     run_square_sum;
   int unsigned                filled;
   int unsigned                ring_pos;
   logic [WLEN_W-1:0]          window_len;

   always #5 clock = ~clock;

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 94) return $urandom_range(1, 4);
      return $urandom_range(10, 120);
   endfunction

   function automatic int unsigned span_of(input logic [WLEN_W-1:0] wlen);
      if (wlen == 0) return 1;
      if (wlen > MAX_WINDOW) return MAX_WINDOW;
      return 32'(wlen);
   endfunction

   function automatic void clear_window();
      run_sum        = 0;
      run_square_sum = 0;
      filled         = 0;
      ring_pos       = 0;
   endfunction

   function automatic zscore_beat_type zscore_of(input logic signed [SAMPLE_W-1:0] x,
                                                 input logic start);
      zscore_beat_type     beat;
      int unsigned         w;
      int                  b;
      longint              xl;
      longint              old;
      logic signed [127:0] wl;
      logic signed [127:0] sl;
      logic signed [127:0] ql;
      logic signed [127:0] xw;
      logic signed [127:0] dev;
      logic signed [127:0] num;
      logic signed [127:0] mag;
      logic [127:0]        root;
      logic [127:0]        cand;
      logic [127:0]        quo;
      xl = longint'(x);
      w  = span_of(window_len);
      if (start) clear_window();
      if (filled >= w) begin
         old = longint'(spread_ring[(ring_pos + MAX_WINDOW - w) % MAX_WINDOW]);
         run_sum        -= old;
         run_square_sum -= old * old;
      end else begin
         filled++;
      end
      spread_ring[ring_pos] = x;
      run_sum        += xl;
      run_square_sum += xl * xl;
      ring_pos = (ring_pos + 1) % MAX_WINDOW;
      beat.zscore       = '0;
      beat.zscore_valid = (filled >= w);
      beat.flat_window  = 1'b0;
      if (beat.zscore_valid) begin
         wl  = 128'(w);
         sl  = 128'(run_sum);
         ql  = 128'(run_square_sum);
         xw  = 128'(xl);
         dev = wl * ql - sl * sl;
         if (dev <= 0) begin
            beat.flat_window = 1'b1;
         end else begin
            root = '0;
            for (b = 47; b >= 0; b--) begin
               cand = root | (128'd1 << b);
               if (cand * cand <= dev) root = cand;
            end
            num = wl * xw - sl;
            mag = (num < 0) ? -num : num;
            quo = (mag << FRAC_SHIFT) / root;
            if (num < 0)
               beat.zscore = (quo > Z_NEG_LIMIT) ? Z_NEG_LIMIT : ZSCORE_W'(-quo);
            else
               beat.zscore = (quo > Z_POS_LIMIT) ? Z_POS_LIMIT : ZSCORE_W'(quo);
         end
      end
      return beat;
   endfunction

   function automatic void push_sample(input logic signed [SAMPLE_W-1:0] x, input logic start);
      stim_beat_type beat;
      beat.kind         = BEAT_SAMPLE;
      beat.sample       = x;
      beat.series_start = start;
      beat.wlen         = '0;
      pending_beats.push_back(beat);
   endfunction

   function automatic void push_control(input beat_kind_type kind, input int unsigned wlen);
      stim_beat_type beat;
      beat.kind         = kind;
      beat.sample       = '0;
      beat.series_start = 1'b0;
      beat.wlen         = WLEN_W'(wlen);
      pending_beats.push_back(beat);
   endfunction

   // Driver: a new beat is launched only once the previous one on either channel has gone.
   always @(posedge clock) begin
      stim_beat_type head;
      logic          req_v;
      logic          csr_v;
      int unsigned   gap_left;
      int unsigned   quiet;
      if (reset) begin
         clear_window();
         window_len = WLEN_W'(WLEN_RESET);
         gap_left   = 0;
         quiet      = 0;
         req_bus.valid <= 1'b0;
         csr_bus.valid <= 1'b0;
      end else begin
         req_v = req_bus.valid && !req_bus.ready;
         csr_v = csr_bus.valid && !csr_bus.ready;
         if (req_bus.valid && req_bus.ready)
            zscores_due.push_back(zscore_of(req_bus.spread_sample, req_bus.series_start));
         if (csr_bus.valid && csr_bus.ready) begin
            window_len = csr_bus.write_data;
            clear_window();
         end
         quiet = (zscores_due.size() == 0) ? quiet + 1 : 0;
         if (!req_v && !csr_v) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_beats.size() > 0) begin
               head = pending_beats[0];
               case (head.kind)
                  BEAT_SAMPLE: begin
                     req_v = 1'b1;
                     req_bus.spread_sample <= head.sample;
                     req_bus.series_start  <= head.series_start;
                     void'(pending_beats.pop_front());
                     gap_left = pick_gap();
                  end
                  BEAT_WLEN: begin
                     if (quiet >= SETTLE_CYCLES) begin
                        csr_v = 1'b1;
                        csr_bus.write_data <= head.wlen;
                        void'(pending_beats.pop_front());
                     end
                  end
                  default: begin
                     if (quiet >= SETTLE_CYCLES) void'(pending_beats.pop_front());
                  end
               endcase
            end
         end
         req_bus.valid <= req_v;
         csr_bus.valid <= csr_v;
      end
   end

   // Monitor: every result beat is checked against the oldest predicted z-score.
   always @(posedge clock) begin
      zscore_beat_type want;
      logic            taken;
      int unsigned     stall_left;
      if (reset) begin
         stall_left = 0;
         rsp_bus.ready <= 1'b0;
      end else begin
         taken = rsp_bus.valid && rsp_bus.ready;
         if (taken) begin
            if (zscores_due.size() == 0) begin
               $error("Result beat with no sample outstanding: zscore %0d", rsp_bus.zscore);
               failures++;
            end else begin
               want = zscores_due.pop_front();
               if (rsp_bus.zscore !== want.zscore) begin
                  $error("zscore: expected %0d, got %0d", want.zscore, rsp_bus.zscore);
                  failures++;
               end
               if (rsp_bus.zscore_valid !== want.zscore_valid) begin
                  $error("zscore_valid: expected %0b, got %0b",
                         want.zscore_valid, rsp_bus.zscore_valid);
                  failures++;
               end
               if (rsp_bus.flat_window !== want.flat_window) begin
                  $error("flat_window: expected %0b, got %0b",
                         want.flat_window, rsp_bus.flat_window);
                  failures++;
               end
            end
            stall_left = pick_gap();
         end else if (stall_left == 0 && $urandom_range(0, 49) == 0) begin
            stall_left = pick_gap();
         end
         rsp_bus.ready <= (stall_left == 0);
         if (stall_left > 0) stall_left--;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int unsigned                phase;
      int unsigned                random_count;
      int unsigned                span;
      int unsigned                n_series;
      int unsigned                series;
      int unsigned                len;
      int unsigned                k;
      int unsigned                roll;
      int unsigned                spread;
      int unsigned                wlen;
      shape_type                  shape;
      longint                     level;
      longint                     v;
      logic signed [SAMPLE_W-1:0] raw;

      clock                 = 1'b0;
      reset                 = 1'b1;
      failures              = 0;
      cycle_count           = 0;
      req_bus.valid         = 1'b0;
      req_bus.spread_sample = '0;
      req_bus.series_start  = 1'b0;
      rsp_bus.ready         = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.write_data    = '0;

      // First a four-sample window: not yet valid, then flat, then sample range extremes.
      push_sample(SAMPLE_W'(SAMPLE_MAX), 1'b0);
      push_control(BEAT_WLEN, 4);
      push_sample('0, 1'b1);
      push_sample('0, 1'b0);
      push_sample('0, 1'b0);
      push_sample('0, 1'b0);
      push_sample(SAMPLE_W'(SAMPLE_MAX), 1'b0);
      push_sample(SAMPLE_W'(SAMPLE_MIN), 1'b0);
      push_sample(SAMPLE_W'(SAMPLE_MIN), 1'b0);
      push_sample(SAMPLE_W'(SAMPLE_MAX), 1'b0);
      push_sample(SAMPLE_W'(-1), 1'b0);
      push_sample(SAMPLE_W'(1), 1'b1);
      push_control(BEAT_WLEN, 1);
      push_sample(SAMPLE_W'(SAMPLE_MAX), 1'b0);
      push_sample(SAMPLE_W'(-1), 1'b0);
      push_control(BEAT_WLEN, 0);
      push_sample(SAMPLE_W'(SAMPLE_MIN), 1'b0);
      push_sample(SAMPLE_W'(5), 1'b0);
      push_control(BEAT_WLEN, 2);
      push_sample(SAMPLE_W'(5), 1'b1);
      push_sample(SAMPLE_W'(7), 1'b0);
      push_sample(SAMPLE_W'(3), 1'b1);
      push_sample(SAMPLE_W'(-1), 1'b0);
      push_control(BEAT_DRAIN, 0);
      push_sample(SAMPLE_W'(-1), 1'b0);
      push_control(BEAT_WLEN, WLEN_MAX);
      push_sample(SAMPLE_W'(123), 1'b0);
      push_sample(SAMPLE_W'(-123), 1'b1);
      push_control(BEAT_WLEN, 3);
      push_sample(SAMPLE_W'(SAMPLE_MAX), 1'b0);
      push_sample(SAMPLE_W'(SAMPLE_MAX), 1'b0);
      push_sample(SAMPLE_W'(SAMPLE_MAX), 1'b0);
      push_sample(SAMPLE_W'(SAMPLE_MIN), 1'b0);

      phase        = 0;
      random_count = 0;
      while (random_count < RANDOM_ITEMS) begin
         if (phase < $size(PHASE_WINDOWS)) begin
            wlen = PHASE_WINDOWS[phase];
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 70)      wlen = $urandom_range(4, 24);
            else if (roll < 85) wlen = $urandom_range(0, 3);
            else if (roll < 97) wlen = $urandom_range(25, 64);
            else                wlen = $urandom_range(MAX_WINDOW + 1, WLEN_MAX);
         end
         phase++;
         push_control(BEAT_WLEN, wlen);
         span     = span_of(WLEN_W'(wlen));
         n_series = (span >= 128) ? 1 : $urandom_range(1, 3);
         for (series = 0; series < n_series; series++) begin
            roll = $urandom_range(0, 99);
            if (roll < 45)      shape = SHAPE_NEAR;
            else if (roll < 70) shape = SHAPE_WIDE;
            else if (roll < 85) shape = SHAPE_EXTREME;
            else                shape = SHAPE_FLAT;
            raw    = SAMPLE_W'($urandom);
            level  = longint'(raw);
            spread = 1 << $urandom_range(0, 14);
            len    = (span > MAX_WINDOW / 2) ? span + $urandom_range(4, 12)
                                             : span + $urandom_range(0, 24);
            if (wlen > MAX_WINDOW && phase > $size(PHASE_WINDOWS)) len = $urandom_range(5, 20);
            for (k = 0; k < len; k++) begin
               case (shape)
                  SHAPE_WIDE: begin
                     raw = SAMPLE_W'($urandom);
                     v   = longint'(raw);
                  end
                  SHAPE_NEAR: begin
                     v = level + longint'($urandom_range(0, spread)) - longint'(spread / 2);
                  end
                  SHAPE_FLAT: begin
                     v = level;
                  end
                  default: begin
                     case ($urandom_range(0, 3))
                        0:       v = SAMPLE_MAX;
                        1:       v = SAMPLE_MIN;
                        2:       v = 0;
                        default: v = -1;
                     endcase
                  end
               endcase
               if (v > SAMPLE_MAX) v = SAMPLE_MAX;
               if (v < SAMPLE_MIN) v = SAMPLE_MIN;
               push_sample(SAMPLE_W'(v), (k == 0) ? ($urandom_range(0, 9) != 0)
                                                  : ($urandom_range(0, 49) == 0));
               random_count++;
            end
            if ($urandom_range(0, 7) == 0) push_control(BEAT_DRAIN, 0);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_beats.size() != 0 || req_bus.valid || csr_bus.valid ||
             zscores_due.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (failures == 0 && zscores_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
